### sv/hsal_pkg.sv
// ----------------------------------------------------------------------------
// hsal_pkg
// Shared types, widths and constant tables of the Hermite segment arc length
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsal_pkg;

  localparam int unsigned QUAD_POINTS = 5;

  // Field widths.
  localparam int unsigned P_W    = 24;  // Q15.8 coordinate
  localparam int unsigned F_W    = 17;  // Q1.16 fraction, 65536 is one
  localparam int unsigned SC_W   = 16;  // Q8.8 scale
  localparam int unsigned S_W    = 40;  // scaled derivative component, Q.8
  localparam int unsigned K_W    = 4;   // magnitude prescale shift
  localparam int unsigned ROOT_W = 32;  // square root of the prescaled sum

  localparam logic [F_W-1:0] FRAC_ONE = 17'h10000;
  localparam int unsigned    RND16    = 32768;

  // Segment modes. Any other code runs as a Hermite curve.
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CONST  = 2'd2;

  // Register index, taken from paddr bit 2.
  localparam logic REG_SCALE_X = 1'b0;
  localparam logic REG_SCALE_Y = 1'b1;

  // Gauss-Legendre nodes mapped to [0,1] and weights, both Q0.16.
  localparam logic [QUAD_POINTS-1:0][15:0] NODE_U = {
    16'd62462, 16'd3074, 16'd50413, 16'd15123, 16'd32768
  };
  localparam logic [QUAD_POINTS-1:0][15:0] WEIGHT = {
    16'd15527, 16'd15527, 16'd31367, 16'd31367, 16'd37283
  };

  typedef struct packed {
    logic signed [P_W-1:0] start_x;
    logic signed [P_W-1:0] start_y;
    logic signed [P_W-1:0] leave_tan_x;
    logic signed [P_W-1:0] leave_tan_y;
    logic signed [P_W-1:0] end_x;
    logic signed [P_W-1:0] end_y;
    logic signed [P_W-1:0] arrive_tan_x;
    logic signed [P_W-1:0] arrive_tan_y;
    logic [F_W-1:0]        fraction;
    logic [1:0]            mode;
  } in_t;

  typedef struct packed {
    logic [31:0] arc_length;
    logic        saturated;
  } out_t;

  typedef struct packed {
    logic signed [SC_W-1:0] x;
    logic signed [SC_W-1:0] y;
  } scale_t;

  // Per-item sideband that rides along the pipeline.
  typedef struct packed {
    logic [F_W-1:0] f;
    logic [1:0]     mode;
  } side_t;

  typedef struct packed {
    logic [QUAD_POINTS-1:0][S_W-1:0] sx;
    logic [QUAD_POINTS-1:0][S_W-1:0] sy;
    side_t                           side;
  } comp_t;

  typedef struct packed {
    logic [QUAD_POINTS-1:0][ROOT_W-1:0] root;
    logic [QUAD_POINTS-1:0][K_W-1:0]    k;
    side_t                              side;
  } root_t;

endpackage

`default_nettype wire

### sv/hermite_segment_arc_length.sv
// ----------------------------------------------------------------------------
// hermite_segment_arc_length
// Scaled arc length of a 2D cubic Hermite segment up to a parameter fraction,
// by five-point Gauss-Legendre quadrature, with linear and constant modes.
//
// Usage: one segment enters per input beat on in_valid_i/in_stall_o with the
// payload in in_data_i; one length leaves per output beat on
// out_valid_o/out_stall_i. A beat moves at a rising edge where valid is high
// and stall is low. The block is a 30-stage pipeline (5 front stages for the
// coefficients, derivative and scale multiply, 20 for the magnitude whose
// square root retires two bits per stage, 5 back stages for the weighted sum
// and fraction). A new beat is accepted every cycle while in_stall_o is low.
// When the receiver stalls, a stage holds only if it is full and the stage
// after it holds, so bubbles close up and the input keeps flowing until the
// pipeline is full. Reset clears every valid bit and sets both scale registers
// to 1.0; the datapath needs none. The scale registers sit on an APB-style
// port at byte 0 (x) and 4 (y) and may only be written while the pipeline is
// empty.
// ----------------------------------------------------------------------------
`default_nettype none

module hermite_segment_arc_length (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hsal_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hsal_pkg::out_t out_data_o
);
  import hsal_pkg::*;

  localparam logic signed [SC_W-1:0] SCALE_ONE = 16'sd256;

  // Configuration registers. The index is paddr bit 2; the low bits are
  // byte offsets within the word and are ignored.
  scale_t scale_q;
  logic   cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q.x <= SCALE_ONE;
      scale_q.y <= SCALE_ONE;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SCALE_X: scale_q.x <= pwdata[SC_W-1:0];
        REG_SCALE_Y: scale_q.y <= pwdata[SC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE_X: prdata = {16'h0000, scale_q.x};
      REG_SCALE_Y: prdata = {16'h0000, scale_q.y};
      default:     prdata = '0;
    endcase
  end

  // The three pipeline sections, linked by valid/stall.
  logic  c2m_valid, c2m_stall;
  comp_t c2m_data;
  logic  m2l_valid, m2l_stall;
  root_t m2l_data;

  hsal_coef u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (c2m_valid),
    .out_stall_i (c2m_stall),
    .out_data_o  (c2m_data)
  );

  hsal_mag u_mag (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c2m_valid),
    .in_stall_o  (c2m_stall),
    .in_data_i   (c2m_data),
    .out_valid_o (m2l_valid),
    .out_stall_i (m2l_stall),
    .out_data_o  (m2l_data)
  );

  hsal_len u_len (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m2l_valid),
    .in_stall_o  (m2l_stall),
    .in_data_i   (m2l_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A clamped length is always the largest code.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.arc_length == '1)
    else $error("saturated flag without a clamped length");

  // With the output stage empty, every stage may advance.
  a_empty_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output stage is empty");

  // Without a stall from the receiver, the whole pipeline moves.
  a_open_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the receiver takes results");

  // A write to the x scale lands in the register.
  a_cfg_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && paddr[2] == REG_SCALE_X |=> scale_q.x == $past(pwdata[SC_W-1:0]))
    else $error("scale x write lost");

endmodule

`default_nettype wire

### sv/hsal_coef.sv
// ----------------------------------------------------------------------------
// hsal_coef
// Front pipeline: polynomial coefficients, node parameters, derivative at the
// five nodes and the scale multiply. Lane 0 carries the chord in linear mode.
// ----------------------------------------------------------------------------
`default_nettype none

module hsal_coef (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hsal_pkg::scale_t scale_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hsal_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hsal_pkg::comp_t  out_data_o
);
  import hsal_pkg::*;

  localparam int unsigned NS     = 5;
  localparam int unsigned CO_W   = 30;
  localparam int unsigned DP_W   = P_W + 1;
  localparam int unsigned A_W    = F_W;
  localparam int unsigned AU_W   = F_W + 17;
  localparam int unsigned AA_W   = 2 * A_W;
  localparam int unsigned C2A_W  = CO_W + A_W + 1;
  localparam int unsigned LIN_W  = DP_W + SC_W;
  localparam int unsigned LS_W   = LIN_W - 8;
  localparam int unsigned D_W    = S_W + 24;
  localparam int unsigned PS_W   = S_W + SC_W;

  function automatic logic signed [CO_W-1:0] coef1(
    input logic signed [P_W-1:0] p0, t0, p1, t1);
    logic signed [CO_W-1:0] d;
    logic signed [CO_W-1:0] s;
    d = CO_W'(p0) - CO_W'(p1);
    s = (d <<< 1) + CO_W'(t0) + CO_W'(t1);
    return (s <<< 1) + s;
  endfunction

  function automatic logic signed [CO_W-1:0] coef2(
    input logic signed [P_W-1:0] p0, t0, p1, t1);
    logic signed [CO_W-1:0] d;
    d = CO_W'(p1) - CO_W'(p0);
    return (d <<< 2) + (d <<< 1) - (CO_W'(t0) <<< 2) - (CO_W'(t1) <<< 1);
  endfunction

  // Valid chain with per-stage bubble collapse.
  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  assign adv[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign v_in        = {v_q[NS-2:0], in_valid_i};
  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 0: coefficients, clamped fraction and node parameters.
  logic [F_W-1:0]                   f_c;
  logic [QUAD_POINTS-1:0][AU_W-1:0] fu;
  logic signed [CO_W-1:0]           c1x_q, c1y_q, c2x_q, c2y_q;
  logic signed [P_W-1:0]            t0x_q, t0y_q;
  logic signed [DP_W-1:0]           dpx_q, dpy_q;
  logic [QUAD_POINTS-1:0][A_W-1:0]  a_q;
  side_t                            side0_q;

  always_comb begin
    f_c = (in_data_i.fraction > FRAC_ONE) ? FRAC_ONE : in_data_i.fraction;
    for (int n = 0; n < QUAD_POINTS; n++) begin
      fu[n] = AU_W'(f_c) * AU_W'(NODE_U[n]) + AU_W'(RND16);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      c1x_q <= coef1(in_data_i.start_x, in_data_i.leave_tan_x,
                     in_data_i.end_x, in_data_i.arrive_tan_x);
      c1y_q <= coef1(in_data_i.start_y, in_data_i.leave_tan_y,
                     in_data_i.end_y, in_data_i.arrive_tan_y);
      c2x_q <= coef2(in_data_i.start_x, in_data_i.leave_tan_x,
                     in_data_i.end_x, in_data_i.arrive_tan_x);
      c2y_q <= coef2(in_data_i.start_y, in_data_i.leave_tan_y,
                     in_data_i.end_y, in_data_i.arrive_tan_y);
      t0x_q <= in_data_i.leave_tan_x;
      t0y_q <= in_data_i.leave_tan_y;
      dpx_q <= DP_W'(in_data_i.end_x) - DP_W'(in_data_i.start_x);
      dpy_q <= DP_W'(in_data_i.end_y) - DP_W'(in_data_i.start_y);
      for (int n = 0; n < QUAD_POINTS; n++) begin
        a_q[n] <= fu[n][A_W+15:16];
      end
      side0_q.f    <= f_c;
      side0_q.mode <= in_data_i.mode;
    end
  end

  // Stage 1: a squared, C2 times a, chord times scale.
  logic signed [CO_W-1:0]           c1x1_q, c1y1_q;
  logic signed [P_W-1:0]            t0x1_q, t0y1_q;
  logic [QUAD_POINTS-1:0][AA_W-1:0] aa1_q;
  logic signed [C2A_W-1:0]          c2ax1_q [QUAD_POINTS];
  logic signed [C2A_W-1:0]          c2ay1_q [QUAD_POINTS];
  logic signed [LIN_W-1:0]          linx1_q, liny1_q;
  side_t                            side1_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      c1x1_q  <= c1x_q;
      c1y1_q  <= c1y_q;
      t0x1_q  <= t0x_q;
      t0y1_q  <= t0y_q;
      for (int n = 0; n < QUAD_POINTS; n++) begin
        aa1_q[n]   <= AA_W'(a_q[n]) * AA_W'(a_q[n]);
        c2ax1_q[n] <= C2A_W'(c2x_q) * $signed(C2A_W'(a_q[n]));
        c2ay1_q[n] <= C2A_W'(c2y_q) * $signed(C2A_W'(a_q[n]));
      end
      linx1_q <= LIN_W'(dpx_q) * LIN_W'(scale_i.x);
      liny1_q <= LIN_W'(dpy_q) * LIN_W'(scale_i.y);
      side1_q <= side0_q;
    end
  end

  // Stage 2: C1 times a squared.
  logic signed [D_W-1:0]   c1aax2_q [QUAD_POINTS];
  logic signed [D_W-1:0]   c1aay2_q [QUAD_POINTS];
  logic signed [C2A_W-1:0] c2ax2_q [QUAD_POINTS];
  logic signed [C2A_W-1:0] c2ay2_q [QUAD_POINTS];
  logic signed [P_W-1:0]   t0x2_q, t0y2_q;
  logic signed [LS_W-1:0]  lsx2_q, lsy2_q;
  side_t                   side2_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        c1aax2_q[n] <= D_W'(c1x1_q) * $signed(D_W'(aa1_q[n]));
        c1aay2_q[n] <= D_W'(c1y1_q) * $signed(D_W'(aa1_q[n]));
        c2ax2_q[n]  <= c2ax1_q[n];
        c2ay2_q[n]  <= c2ay1_q[n];
      end
      t0x2_q  <= t0x1_q;
      t0y2_q  <= t0y1_q;
      lsx2_q  <= linx1_q[LIN_W-1:8];
      lsy2_q  <= liny1_q[LIN_W-1:8];
      side2_q <= side1_q;
    end
  end

  // Stage 3: derivative sum in Q.40, floor shifted down to Q.16.
  logic signed [D_W-1:0]  dfx [QUAD_POINTS];
  logic signed [D_W-1:0]  dfy [QUAD_POINTS];
  logic signed [S_W-1:0]  dx3_q [QUAD_POINTS];
  logic signed [S_W-1:0]  dy3_q [QUAD_POINTS];
  logic signed [LS_W-1:0] lsx3_q, lsy3_q;
  side_t                  side3_q;

  always_comb begin
    for (int n = 0; n < QUAD_POINTS; n++) begin
      dfx[n] = c1aax2_q[n] + (D_W'(c2ax2_q[n]) <<< 16) + (D_W'(t0x2_q) <<< 32);
      dfy[n] = c1aay2_q[n] + (D_W'(c2ay2_q[n]) <<< 16) + (D_W'(t0y2_q) <<< 32);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        dx3_q[n] <= dfx[n][D_W-1:24];
        dy3_q[n] <= dfy[n][D_W-1:24];
      end
      lsx3_q  <= lsx2_q;
      lsy3_q  <= lsy2_q;
      side3_q <= side2_q;
    end
  end

  // Stage 4: scale multiply; lane 0 takes the chord in linear mode.
  logic signed [PS_W-1:0] psx [QUAD_POINTS];
  logic signed [PS_W-1:0] psy [QUAD_POINTS];
  comp_t                  out_q;

  always_comb begin
    for (int n = 0; n < QUAD_POINTS; n++) begin
      psx[n] = PS_W'(dx3_q[n]) * PS_W'(scale_i.x);
      psy[n] = PS_W'(dy3_q[n]) * PS_W'(scale_i.y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        if (n == 0 && side3_q.mode == MODE_LINEAR) begin
          out_q.sx[n] <= S_W'(lsx3_q);
          out_q.sy[n] <= S_W'(lsy3_q);
        end else begin
          out_q.sx[n] <= psx[n][PS_W-1:16];
          out_q.sy[n] <= psy[n][PS_W-1:16];
        end
      end
      out_q.side <= side3_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

### sv/hsal_mag.sv
// ----------------------------------------------------------------------------
// hsal_mag
// Magnitude pipeline for all lanes: absolute value, prescale so that both
// components fit 31 bits, squares, sum and a digit-by-digit square root at
// two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hsal_mag (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hsal_pkg::comp_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output hsal_pkg::root_t out_data_o
);
  import hsal_pkg::*;

  localparam int unsigned N_W    = 31;
  localparam int unsigned SQ_W   = 2 * N_W;
  localparam int unsigned V_W    = SQ_W + 1;
  localparam int unsigned R_W    = 64;
  localparam int unsigned ISQ_ST = ROOT_W / 2;
  localparam int unsigned PRE    = 4;
  localparam int unsigned NS     = PRE + ISQ_ST;

  function automatic logic [S_W-1:0] absv(input logic [S_W-1:0] v);
    return v[S_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [2*R_W-1:0] sq_step(
    input logic [R_W-1:0] rem, res, bitv);
    logic [R_W-1:0] trial;
    trial = res + bitv;
    if (rem >= trial) begin
      return {rem - trial, (res >> 1) + bitv};
    end
    return {rem, res >> 1};
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  assign adv[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign v_in        = {v_q[NS-2:0], in_valid_i};
  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 0: absolute values.
  logic [QUAD_POINTS-1:0][S_W-1:0] ax0_q, ay0_q;
  side_t                           side0_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        ax0_q[n] <= absv(in_data_i.sx[n]);
        ay0_q[n] <= absv(in_data_i.sy[n]);
      end
      side0_q <= in_data_i.side;
    end
  end

  // Stage 1: shift both components right until they fit 31 bits.
  logic [QUAD_POINTS-1:0][S_W-1:0] orv, shx, shy;
  logic [QUAD_POINTS-1:0][K_W-1:0] kc;
  logic [QUAD_POINTS-1:0][N_W-1:0] nx1_q, ny1_q;
  logic [QUAD_POINTS-1:0][K_W-1:0] k1_q;
  side_t                           side1_q;

  always_comb begin
    for (int n = 0; n < QUAD_POINTS; n++) begin
      orv[n] = ax0_q[n] | ay0_q[n];
      kc[n]  = '0;
      for (int i = N_W; i < S_W; i++) begin
        if (orv[n][i]) begin
          kc[n] = K_W'(i - N_W + 1);
        end
      end
      shx[n] = ax0_q[n] >> kc[n];
      shy[n] = ay0_q[n] >> kc[n];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        nx1_q[n] <= shx[n][N_W-1:0];
        ny1_q[n] <= shy[n][N_W-1:0];
      end
      k1_q    <= kc;
      side1_q <= side0_q;
    end
  end

  // Stage 2: squares.
  logic [QUAD_POINTS-1:0][SQ_W-1:0] sqx2_q, sqy2_q;
  logic [QUAD_POINTS-1:0][K_W-1:0]  k2_q;
  side_t                            side2_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        sqx2_q[n] <= SQ_W'(nx1_q[n]) * SQ_W'(nx1_q[n]);
        sqy2_q[n] <= SQ_W'(ny1_q[n]) * SQ_W'(ny1_q[n]);
      end
      k2_q    <= k1_q;
      side2_q <= side1_q;
    end
  end

  // Stage 3 loads row 0 of the root pipeline; stages after it refine it.
  logic [ISQ_ST:0][QUAD_POINTS-1:0][R_W-1:0] rem_q, res_q;
  logic [ISQ_ST:0][QUAD_POINTS-1:0][K_W-1:0] k_q;
  side_t                                     side_q [ISQ_ST+1];
  logic [ISQ_ST-1:0][QUAD_POINTS-1:0][R_W-1:0] rem_d, res_d;

  always_comb begin
    logic [2*R_W-1:0] st;
    logic [R_W-1:0]   bitv;
    for (int j = 0; j < ISQ_ST; j++) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        st = {rem_q[j][n], res_q[j][n]};
        for (int t = 0; t < 2; t++) begin
          bitv = R_W'(1) << (R_W - 2 - 2 * (2 * j + t));
          st   = sq_step(st[2*R_W-1:R_W], st[R_W-1:0], bitv);
        end
        rem_d[j][n] = st[2*R_W-1:R_W];
        res_d[j][n] = st[R_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[PRE-1]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        rem_q[0][n] <= R_W'(V_W'(sqx2_q[n]) + V_W'(sqy2_q[n]));
        res_q[0][n] <= '0;
      end
      k_q[0]    <= k2_q;
      side_q[0] <= side2_q;
    end
    for (int j = 0; j < ISQ_ST; j++) begin
      if (adv[PRE+j]) begin
        rem_q[j+1]  <= rem_d[j];
        res_q[j+1]  <= res_d[j];
        k_q[j+1]    <= k_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  always_comb begin
    for (int n = 0; n < QUAD_POINTS; n++) begin
      out_data_o.root[n] = res_q[ISQ_ST][n][ROOT_W-1:0];
    end
    out_data_o.k    = k_q[ISQ_ST];
    out_data_o.side = side_q[ISQ_ST];
  end

endmodule

`default_nettype wire

### sv/hsal_len.sv
// ----------------------------------------------------------------------------
// hsal_len
// Back pipeline: undo the prescale, weight and sum the node magnitudes,
// multiply by the fraction, select by mode and saturate into the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsal_len (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hsal_pkg::root_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output hsal_pkg::out_t  out_data_o
);
  import hsal_pkg::*;

  localparam int unsigned NS     = 5;
  localparam int unsigned M_W    = ROOT_W + 9;
  localparam int unsigned WM_W   = M_W + 16;
  localparam int unsigned LP_W   = M_W + F_W;
  localparam int unsigned ACC_W  = WM_W + 3;
  localparam int unsigned ACCR_W = ACC_W - 8;
  localparam int unsigned LIN_W  = LP_W - 16;
  localparam int unsigned HB     = 26;
  localparam int unsigned PH_W   = ACCR_W - HB + F_W;
  localparam int unsigned PL_W   = HB + F_W;
  localparam int unsigned TOT_W  = PH_W + HB + 1;
  localparam int unsigned L_W    = TOT_W - 25;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  assign adv[NS] = !out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end
  assign v_in        = {v_q[NS-2:0], in_valid_i};
  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 0: magnitude back to full scale.
  logic [QUAD_POINTS-1:0][M_W-1:0] m0_q;
  side_t                           side0_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        m0_q[n] <= M_W'(in_data_i.root[n]) << in_data_i.k[n];
      end
      side0_q <= in_data_i.side;
    end
  end

  // Stage 1: weights, and the linear length product on lane 0.
  logic [QUAD_POINTS-1:0][WM_W-1:0] wm1_q;
  logic [LP_W-1:0]                  lp1_q;
  side_t                            side1_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int n = 0; n < QUAD_POINTS; n++) begin
        wm1_q[n] <= WM_W'(m0_q[n]) * WM_W'(WEIGHT[n]);
      end
      lp1_q   <= LP_W'(m0_q[0]) * LP_W'(side0_q.f);
      side1_q <= side0_q;
    end
  end

  // Stage 2: weighted sum with rounding, and linear rounding.
  logic [ACC_W-1:0]  acc;
  logic [LP_W-1:0]   lpr;
  logic [ACCR_W-1:0] accr2_q;
  logic [LIN_W-1:0]  lin2_q;
  side_t             side2_q;

  always_comb begin
    acc = ACC_W'(128);
    for (int n = 0; n < QUAD_POINTS; n++) begin
      acc = acc + ACC_W'(wm1_q[n]);
    end
    lpr = lp1_q + LP_W'(RND16);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      accr2_q <= acc[ACC_W-1:8];
      lin2_q  <= lpr[LP_W-1:16];
      side2_q <= side1_q;
    end
  end

  // Stage 3: curve length times fraction, as two partial products.
  logic [PH_W-1:0]  ph3_q;
  logic [PL_W-1:0]  pl3_q;
  logic [LIN_W-1:0] lin3_q;
  side_t            side3_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      ph3_q   <= PH_W'(accr2_q[ACCR_W-1:HB]) * PH_W'(side2_q.f);
      pl3_q   <= PL_W'(accr2_q[HB-1:0]) * PL_W'(side2_q.f);
      lin3_q  <= lin2_q;
      side3_q <= side2_q;
    end
  end

  // Stage 4: combine, select by mode, saturate.
  logic [TOT_W-1:0] tot;
  logic [L_W-1:0]   lenw;
  logic             sat;
  out_t             out_q;

  always_comb begin
    tot = (TOT_W'(ph3_q) << HB) + TOT_W'(pl3_q) + (TOT_W'(1) << 24);
    case (side3_q.mode)
      MODE_LINEAR: lenw = L_W'(lin3_q);
      MODE_CONST:  lenw = '0;
      default:     lenw = tot[TOT_W-1:25];
    endcase
    sat = |lenw[L_W-1:32];
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      out_q.arc_length <= sat ? '1 : lenw[31:0];
      out_q.saturated  <= sat;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
